>>> sv/rpl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpl_pkg
// Shared types and constants for the route prefix lookup chain.
// ----------------------------------------------------------------------------
package rpl_pkg;

    // Table depth, one cell per entry
    localparam int ROUTE_ENTRIES = 16;
    localparam int IDX_W         = 4;
    localparam int COUNT_W       = 5;
    localparam int CFG_DATA_W    = 5;
    localparam int CFG_INDEX_W   = 1;

    // Command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Match modes
    localparam logic MODE_LONGEST = 1'b0;
    localparam logic MODE_FIRST   = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ROUTE_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_MODE  = 1'b1;

    // Input transaction
    typedef struct packed {
        logic             command;
        logic [IDX_W-1:0] entry_index;
        logic [31:0]      route_prefix;
        logic [31:0]      route_mask;
        logic [3:0]       route_port;
        logic [31:0]      lookup_addr;
    } rpl_in_t;

    // Result transaction
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] match_index;
        logic [3:0]       match_port;
    } rpl_out_t;

    // Configuration seen by every cell
    typedef struct packed {
        logic [COUNT_W-1:0] route_count;
        logic               match_mode;
    } rpl_cfg_t;

    // Token handed from cell to cell
    typedef struct packed {
        logic             valid;
        rpl_in_t          item;
        logic             found;
        logic [IDX_W-1:0] best_index;
        logic [31:0]      best_mask;
        logic [3:0]       best_port;
    } rpl_token_t;

endpackage

>>> sv/rpl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpl_cell
// One table entry and one stage of the search chain: applies writes aimed at
// its slot and folds its entry into the passing lookup's best match.
// ----------------------------------------------------------------------------
module rpl_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [rpl_pkg::IDX_W-1:0] cell_index,
    input  rpl_pkg::rpl_cfg_t         cfg,
    input  rpl_pkg::rpl_token_t       tok_in,
    output rpl_pkg::rpl_token_t       tok_out
);

    logic [31:0] prefix_reg;
    logic [31:0] mask_reg;
    logic [3:0]  port_reg;

    rpl_pkg::rpl_token_t tok_reg;
    rpl_pkg::rpl_token_t tok_next;

    logic is_write;
    logic is_lookup;
    logic in_range;
    logic match;
    logic take;

    assign is_write  = tok_in.valid && (tok_in.item.command == rpl_pkg::CMD_WRITE);
    assign is_lookup = tok_in.valid && (tok_in.item.command == rpl_pkg::CMD_LOOKUP);
    assign in_range  = {1'b0, cell_index} < cfg.route_count;

    // Match test and selection for this entry
    always_comb
    begin
        if (cfg.match_mode == rpl_pkg::MODE_LONGEST)
        begin
            match = (tok_in.item.lookup_addr & mask_reg) == (prefix_reg & mask_reg);
            take  = match && (!tok_in.found || (mask_reg > tok_in.best_mask));
        end
        else
        begin
            match = (tok_in.item.lookup_addr & mask_reg) == prefix_reg;
            take  = match && !tok_in.found;
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        if (is_lookup && in_range && take)
        begin
            tok_next.found      = 1'b1;
            tok_next.best_index = cell_index;
            tok_next.best_mask  = mask_reg;
            tok_next.best_port  = port_reg;
        end
    end

    // Entry storage, no reset: an entry must be read only after written; the block does not enforce this
    always_ff @(posedge clk)
    begin
        if (is_write && (tok_in.item.entry_index == cell_index))
        begin
            prefix_reg <= tok_in.item.route_prefix;
            mask_reg   <= tok_in.item.route_mask;
            port_reg   <= tok_in.item.route_port;
        end
    end

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> sv/route_prefix_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_prefix_lookup
// IPv4 route table with longest-prefix or first-match search.
// ----------------------------------------------------------------------------
// A chain of 16 cells, one per table entry, carries every transaction (write
// or lookup) from slot 0 to slot 15, one cell per cycle. busy is never
// raised, so a new transaction is taken on every clock; done is high when
// the transaction leaves the stage register of slot 15, and results come
// out in the order taken. Results cannot be stalled: the receiver must
// take each one in the cycle done is high.
// Writes travel the chain in order with lookups, so a lookup always sees
// exactly the writes taken before it. Configuration must only be written
// while no transaction is in flight.
// ----------------------------------------------------------------------------
module route_prefix_lookup
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rpl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rpl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            start,
    output logic                            busy,
    input  rpl_pkg::rpl_in_t                request,
    output logic                            done,
    output rpl_pkg::rpl_out_t               result
);

    rpl_pkg::rpl_cfg_t   cfg_reg;
    rpl_pkg::rpl_token_t tok [rpl_pkg::ROUTE_ENTRIES+1];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.route_count <= '0;
            cfg_reg.match_mode  <= rpl_pkg::MODE_LONGEST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rpl_pkg::CFG_ROUTE_COUNT: cfg_reg.route_count <= cfg_data;
                rpl_pkg::CFG_MATCH_MODE:  cfg_reg.match_mode  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Chain always advances
    assign busy = 1'b0;

    // Head token
    always_comb
    begin
        tok[0].valid      = start;
        tok[0].item       = request;
        tok[0].found      = 1'b0;
        tok[0].best_index = '0;
        tok[0].best_mask  = '0;
        tok[0].best_port  = '0;
    end

    // Cell chain
    for (genvar g = 0; g < rpl_pkg::ROUTE_ENTRIES; g++)
    begin : g_cell
        rpl_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (rpl_pkg::IDX_W'(g)),
            .cfg        (cfg_reg),
            .tok_in     (tok[g]),
            .tok_out    (tok[g+1])
        );
    end

    // Result from the last stage; writes never set found
    assign done               = tok[rpl_pkg::ROUTE_ENTRIES].valid;
    assign result.hit         = tok[rpl_pkg::ROUTE_ENTRIES].found;
    assign result.match_index = tok[rpl_pkg::ROUTE_ENTRIES].best_index;
    assign result.match_port  = tok[rpl_pkg::ROUTE_ENTRIES].best_port;

endmodule

>>> sv/rpl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpl_checker
// Port-level checks on the route prefix lookup, bound to the top level.
// ----------------------------------------------------------------------------
module rpl_checker
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  rpl_pkg::rpl_in_t  request,
    input  logic              done,
    input  rpl_pkg::rpl_out_t result
);

    localparam int LAT = rpl_pkg::ROUTE_ENTRIES;

    // Every accepted transaction yields a result after the chain latency
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted transaction produced no result");

    // No result without a matching accepted transaction
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a transaction");

    // Writes never report a hit
    a_write_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(start && !busy && (request.command == rpl_pkg::CMD_WRITE), LAT))
        |-> !result.hit)
        else $error("write reported a hit");

    // A miss reports zero index and port
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |-> (result.match_index == '0) && (result.match_port == '0))
        else $error("miss with non-zero index or port");

endmodule

bind route_prefix_lookup rpl_checker u_rpl_checker
(
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the route prefix lookup chain. A route table shadow
// predicts hit, index and port for every accepted transaction, in both
// longest-prefix and first-match modes, over several route counts. Directed
// routes cover nesting, ties, unmasked prefix bits and the default route;
// random routes and lookups are aimed at stored entries so most searches hit.
// ----------------------------------------------------------------------------
module testbench;

    import rpl_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 32;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 160;

    // ------------------------------------------------------------------------
    // Route table shadow and result checker
    // ------------------------------------------------------------------------
    class route_scoreboard;
        logic [31:0]        prefix_tab [ROUTE_ENTRIES];
        logic [31:0]        mask_tab   [ROUTE_ENTRIES];
        logic [3:0]         port_tab   [ROUTE_ENTRIES];
        logic [COUNT_W-1:0] count_reg;
        logic               mode_reg;
        rpl_out_t           expected_q [$];
        int                 failures;

        function new();
            for (int i = 0; i < ROUTE_ENTRIES; i++)
            begin
                prefix_tab[i] = '0;
                mask_tab[i]   = '0;
                port_tab[i]   = '0;
            end
            count_reg = '0;
            mode_reg  = MODE_LONGEST;
            failures  = 0;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10)
                $display("%s", msg);
        endfunction

        function void note_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_ROUTE_COUNT)
                count_reg = data[COUNT_W-1:0];
            else if (idx == CFG_MATCH_MODE)
                mode_reg = data[0];
        endfunction

        // Search the table the way the chain does; writes update the shadow
        function rpl_out_t route_search(rpl_in_t it);
            rpl_out_t    res;
            int          lim;
            int          best;
            logic        found;
            logic [31:0] m;
            res   = '0;
            found = 1'b0;
            best  = 0;
            if (it.command == CMD_WRITE)
            begin
                prefix_tab[it.entry_index] = it.route_prefix;
                mask_tab[it.entry_index]   = it.route_mask;
                port_tab[it.entry_index]   = it.route_port;
                return res;
            end
            lim = (count_reg > ROUTE_ENTRIES) ? ROUTE_ENTRIES : int'(count_reg);
            for (int i = 0; i < lim; i++)
            begin
                m = mask_tab[i];
                if (mode_reg == MODE_LONGEST)
                begin
                    // greatest mask wins, lower slot on a tie
                    if ((it.lookup_addr & m) == (prefix_tab[i] & m))
                        if (!found || m > mask_tab[best])
                        begin
                            found = 1'b1;
                            best  = i;
                        end
                end
                else if (!found && ((it.lookup_addr & m) == prefix_tab[i]))
                begin
                    found = 1'b1;
                    best  = i;
                end
            end
            if (found)
            begin
                res.hit         = 1'b1;
                res.match_index = best[IDX_W-1:0];
                res.match_port  = port_tab[best];
            end
            return res;
        endfunction

        function void note_input(rpl_in_t it);
            expected_q.push_back(route_search(it));
        endfunction

        function void check_result(rpl_out_t got);
            rpl_out_t want;
            if (expected_q.size() == 0)
            begin
                flag($sformatf("unexpected result: hit %0d index %0d port %0d",
                               got.hit, got.match_index, got.match_port));
                return;
            end
            want = expected_q.pop_front();
            if (got.hit !== want.hit || got.match_index !== want.match_index
                || got.match_port !== want.match_port)
                flag($sformatf("mismatch: expected hit %0d index %0d port %0d, got hit %0h index %0h port %0h",
                               want.hit, want.match_index, want.match_port,
                               got.hit, got.match_index, got.match_port));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void close();
            if (expected_q.size() != 0)
                flag($sformatf("%0d results never arrived", expected_q.size()));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block inputs
    // ------------------------------------------------------------------------
    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   start     = 1'b0;
    logic                   busy;
    rpl_in_t                request   = '0;
    logic                   done;
    rpl_out_t               result;

    route_scoreboard sb;
    int              idle_cycles = 0;

    // Stimulus-side copy of the table, used only to aim lookups and related routes
    logic [31:0] aim_prefix [ROUTE_ENTRIES];
    logic [31:0] aim_mask   [ROUTE_ENTRIES];

    always #6 clk = ~clk;

    route_prefix_lookup dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result)
    );

    // Monitor: accepted transactions, results and register writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.note_config(cfg_index, cfg_data);
            if (start && !busy)
                sb.note_input(request);
            if (done)
                sb.check_result(result);
        end
    end

    // Watchdog on cycles with no accepted transaction, result or register write at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [31:0] len_mask(int len);
        return 32'hFFFF_FFFF << (32 - len);
    endfunction

    function automatic rpl_in_t route_write(int slot, logic [31:0] pfx,
                                            logic [31:0] msk, logic [3:0] port);
        rpl_in_t it;
        it.command      = CMD_WRITE;
        it.entry_index  = slot[IDX_W-1:0];
        it.route_prefix = pfx;
        it.route_mask   = msk;
        it.route_port   = port;
        it.lookup_addr  = $urandom;
        aim_prefix[slot[IDX_W-1:0]] = pfx;
        aim_mask[slot[IDX_W-1:0]]   = msk;
        return it;
    endfunction

    function automatic rpl_in_t addr_lookup(logic [31:0] addr);
        rpl_in_t it;
        it.command      = CMD_LOOKUP;
        it.entry_index  = IDX_W'($urandom_range(0, ROUTE_ENTRIES - 1));
        it.route_prefix = $urandom;
        it.route_mask   = $urandom;
        it.route_port   = 4'($urandom_range(0, 15));
        it.lookup_addr  = addr;
        return it;
    endfunction

    // Random route, often related to an existing one so searches compete
    function automatic rpl_in_t random_write();
        int               slot;
        logic [IDX_W-1:0] j;
        int               r;
        logic [31:0]      msk;
        logic [31:0]      pfx;
        slot = $urandom_range(0, ROUTE_ENTRIES - 1);
        j    = IDX_W'($urandom_range(0, ROUTE_ENTRIES - 1));
        r    = $urandom_range(0, 99);
        msk  = len_mask($urandom_range(0, 32));
        if (r < 40)
            pfx = $urandom & msk;
        else if (r < 65)
            pfx = (aim_prefix[j] & msk) | ($urandom & msk & ~aim_mask[j]);
        else if (r < 80)
        begin
            msk = aim_mask[j];
            pfx = aim_prefix[j];
        end
        else if (r < 90)
            pfx = $urandom;
        else
        begin
            msk = $urandom;
            pfx = $urandom;
        end
        return route_write(slot, pfx, msk, 4'($urandom_range(0, 15)));
    endfunction

    // Lookup mostly aimed inside a stored route
    function automatic rpl_in_t random_lookup();
        logic [IDX_W-1:0] j;
        int               r;
        logic [31:0]      addr;
        j = IDX_W'($urandom_range(0, ROUTE_ENTRIES - 1));
        r = $urandom_range(0, 99);
        if (r < 75)
            addr = (aim_prefix[j] & aim_mask[j]) | ($urandom & ~aim_mask[j]);
        else if (r < 85)
            addr = aim_prefix[j];
        else
            addr = $urandom;
        return addr_lookup(addr);
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Present one transaction and hold it until taken
    task automatic drive(input rpl_in_t it, input int gap);
        start   <= 1'b1;
        request <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait for every result to come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Both registers, written back to back while the chain is empty
    task automatic set_config(input logic [CFG_DATA_W-1:0] count,
                              input logic [CFG_DATA_W-1:0] mode_data);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROUTE_COUNT;
        cfg_data  <= count;
        @(posedge clk);
        cfg_index <= CFG_MATCH_MODE;
        cfg_data  <= mode_data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic directed_lookups();
        drive(addr_lookup(32'h0A01_0203), random_gap());
        drive(addr_lookup(32'h0A01_0209), random_gap());
        drive(addr_lookup(32'hC0A8_0105), random_gap());
        drive(addr_lookup(32'hFFFF_FFFF), random_gap());
        drive(addr_lookup(32'h0B00_0000), random_gap());
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [CFG_DATA_W-1:0] count;
        logic                  mode;
        logic                  no_gaps;
        sb = new();
        for (int i = 0; i < ROUTE_ENTRIES; i++)
        begin
            aim_prefix[i] = '0;
            aim_mask[i]   = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Count zero after reset: nothing is searched
        drive(addr_lookup(32'h0A01_0203), 0);

        // Fill every slot: nested routes, a tie, raw prefix bits, default last
        drive(route_write(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15), random_gap());
        drive(route_write(1, 32'h0A00_0000, len_mask(8), 4'd1), random_gap());
        drive(route_write(2, 32'h0A01_0000, len_mask(16), 4'd2), random_gap());
        drive(route_write(3, 32'h0A01_0200, len_mask(24), 4'd3), random_gap());
        drive(route_write(4, 32'h0A01_0203, len_mask(32), 4'd4), random_gap());
        drive(route_write(5, 32'h0A01_0200, len_mask(24), 4'd5), random_gap());
        drive(route_write(6, 32'hC0A8_014D, len_mask(24), 4'd6), random_gap());
        for (int s = 7; s < ROUTE_ENTRIES - 1; s++)
            drive(route_write(s, $urandom & len_mask(20), len_mask(20),
                              4'($urandom_range(0, 15))), random_gap());
        drive(route_write(ROUTE_ENTRIES - 1, 32'h0, 32'h0, 4'd0), random_gap());
        drain();

        // Full table, longest match
        set_config(CFG_DATA_W'(ROUTE_ENTRIES), {4'b0000, MODE_LONGEST});
        directed_lookups();
        drain();

        // Saturating count, first match, upper data bits set
        set_config(5'd31, {4'b1111, MODE_FIRST});
        directed_lookups();
        drain();

        // Random phases over a spread of settings
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin count = CFG_DATA_W'(ROUTE_ENTRIES); mode = MODE_LONGEST; end
                1: begin count = 5'd0;                       mode = MODE_FIRST;   end
                2: begin count = 5'd31;                      mode = MODE_FIRST;   end
                3: begin count = 5'd1;                       mode = MODE_LONGEST; end
                default:
                begin
                    case ($urandom_range(0, 3))
                        0:       count = CFG_DATA_W'($urandom_range(17, 31));
                        1:       count = CFG_DATA_W'(ROUTE_ENTRIES);
                        default: count = CFG_DATA_W'($urandom_range(0, ROUTE_ENTRIES - 1));
                    endcase
                    mode = 1'($urandom_range(0, 1));
                end
            endcase
            set_config(count, {4'($urandom_range(0, 15)), mode});
            no_gaps = (p % 3 == 2);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(0, 99) < 30)
                    drive(random_write(), no_gaps ? 0 : random_gap());
                else
                    drive(random_lookup(), no_gaps ? 0 : random_gap());
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.close();
        if (sb.failures == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

>>> route_prefix_lookup.f
sv/rpl_pkg.sv
sv/rpl_cell.sv
sv/route_prefix_lookup.sv
sv/rpl_checker.sv
tb/sv/testbench.sv
